// File: rtl/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

  // Field widths of one request.
  localparam int WORD_W = 32;
  localparam int REQ_W  = 3;

  // Request codes as they arrive on the input stream.
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd4;

  // Decoded operation handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_QUERY
  } op_t;

  // One decoded command in the command queue.
  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] value;
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_EXEC,
    ST_READ,
    ST_OUT
  } state_t;

endpackage

// File: rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// Path: front-end input register, two-entry command queue, back-end sequencer
// (execute, optional store read through its single read port for a pop that must fetch
// the new end word from the word store, deliver) and output register. The sequencer takes
// no new command until it has delivered the last result; a stalled output holds it.
// Reset: synchronous, clears head, count, queues and handshakes; the word store is not cleared.

module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH = 1024,
  localparam int CW   = $clog2(DEPTH + 1),
  localparam int TDW  = ((WORD_W + CW + 1 + WORD_W + WORD_W + 1) + 7) / 8 * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [WORD_W-1:0] s_tdata,  // push_value
  input  logic [REQ_W-1:0]  s_tuser,  // req_type
  output logic              m_tvalid,
  input  logic              m_tready,
  // popped_value, entry_count, is_empty, front_value, back_value, push_dropped
  output logic [TDW-1:0]    m_tdata,
  output logic [1:0]        m_tuser   // popped_valid, ends_valid
);

  logic dec_valid;
  logic dec_ready;
  cmd_t dec_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  // Front end: accept and classify requests.
  dq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (dec_valid),
    .cmd       (dec_cmd),
    .cmd_ready (dec_ready)
  );

  // Short command queue between the two halves.
  dq_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (dec_valid),
    .push_ready (dec_ready),
    .push_cmd   (dec_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  // Back end: circular buffer, pointers and result register.
  dq_back #(
    .DEPTH (DEPTH),
    .CW    (CW),
    .TDW   (TDW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// File: rtl/dq_front.sv
`timescale 1ns / 1ps

module dq_front
  import dq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [WORD_W-1:0] s_tdata,  // push_value
  input  logic [REQ_W-1:0]  s_tuser,  // req_type
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_ready
);

  cmd_t cmd_reg;
  logic cmd_held;
  op_t  op_dec;

  // Classify the request code; unused codes act as a query.
  always_comb begin
    unique case (s_tuser)
      REQ_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
      REQ_PUSH_BACK:  op_dec = OP_PUSH_BACK;
      REQ_POP_FRONT:  op_dec = OP_POP_FRONT;
      REQ_POP_BACK:   op_dec = OP_POP_BACK;
      default:        op_dec = OP_QUERY;
    endcase
  end

  // The stage takes a new transaction when it is empty or being drained.
  assign s_tready  = !cmd_held || cmd_ready;
  assign cmd_valid = cmd_held;
  assign cmd       = cmd_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_held <= 1'b0;
    end else if (s_tready) begin
      cmd_held <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd_reg.op    <= op_dec;
      cmd_reg.value <= s_tdata;
    end
  end

endmodule

// File: rtl/dq_cmd_fifo.sv
`timescale 1ns / 1ps

module dq_cmd_fifo
  import dq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: rtl/dq_back.sv
`timescale 1ns / 1ps

module dq_back
  import dq_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int CW    = $clog2(DEPTH + 1),
  parameter int TDW   = ((WORD_W + CW + 1 + WORD_W + WORD_W + 1) + 7) / 8 * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  cmd_t           cmd,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [TDW-1:0] m_tdata,
  output logic [1:0]     m_tuser
);

  localparam int AW = $clog2(DEPTH);
  localparam int RW = WORD_W + CW + 1 + WORD_W + WORD_W + 1;
  localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULL    = CW'(DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

  // Word store: one write port, one registered read port.
  logic [WORD_W-1:0] word_store [DEPTH];
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;

  state_t            state, state_next;
  logic [AW-1:0]     head, head_next;
  logic [CW-1:0]     count, count_next;
  logic [WORD_W-1:0] front_word, front_word_next;
  logic [WORD_W-1:0] back_word, back_word_next;
  logic              rd_to_front, rd_to_front_next;
  logic [WORD_W-1:0] popped_value, popped_value_next;
  logic              popped_valid, popped_valid_next;
  logic              push_dropped, push_dropped_next;
  logic              out_load;
  logic [RW-1:0]     result;

  // Index of the entry at a given offset from the head, modulo DEPTH.
  function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] base,
                                            input logic [CW-1:0] offset);
    logic [CW:0] sum;
    sum = (CW + 1)'(base) + (CW + 1)'(offset);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      word_store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= word_store[rd_addr];
    end
  end

  // Sequencer: execute a command, refill an end word if needed, deliver.
  always_comb begin
    state_next        = state;
    head_next         = head;
    count_next        = count;
    front_word_next   = front_word;
    back_word_next    = back_word;
    rd_to_front_next  = rd_to_front;
    popped_value_next = popped_value;
    popped_valid_next = popped_valid;
    push_dropped_next = push_dropped;
    cmd_ready         = 1'b0;
    wr_en             = 1'b0;
    wr_addr           = head;
    wr_data           = cmd.value;
    rd_en             = 1'b0;
    rd_addr           = head;
    out_load          = 1'b0;

    unique case (state)
      ST_EXEC: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          popped_value_next = '0;
          popped_valid_next = 1'b0;
          push_dropped_next = 1'b0;
          unique case (cmd.op)
            OP_PUSH_FRONT: begin
              if (count == FULL) begin
                push_dropped_next = 1'b1;
              end else begin
                head_next       = (head == '0) ? LAST : head - AW'(1);
                wr_en           = 1'b1;
                wr_addr         = head_next;
                count_next      = count + CW'(1);
                front_word_next = cmd.value;
                if (count == '0) begin
                  back_word_next = cmd.value;
                end
              end
            end
            OP_PUSH_BACK: begin
              if (count == FULL) begin
                push_dropped_next = 1'b1;
              end else begin
                wr_en          = 1'b1;
                wr_addr        = slot_at(head, count);
                count_next     = count + CW'(1);
                back_word_next = cmd.value;
                if (count == '0) begin
                  front_word_next = cmd.value;
                end
              end
            end
            OP_POP_FRONT: begin
              if (count != '0) begin
                popped_value_next = front_word;
                popped_valid_next = 1'b1;
                head_next         = slot_at(head, CW'(1));
                count_next        = count - CW'(1);
                if (count == CW'(2)) begin
                  front_word_next = back_word;
                end else if (count > CW'(2)) begin
                  rd_en            = 1'b1;
                  rd_addr          = head_next;
                  rd_to_front_next = 1'b1;
                end
              end
            end
            OP_POP_BACK: begin
              if (count != '0) begin
                popped_value_next = back_word;
                popped_valid_next = 1'b1;
                count_next        = count - CW'(1);
                if (count == CW'(2)) begin
                  back_word_next = front_word;
                end else if (count > CW'(2)) begin
                  rd_en            = 1'b1;
                  rd_addr          = slot_at(head, count - CW'(2));
                  rd_to_front_next = 1'b0;
                end
              end
            end
            default: begin
            end
          endcase
          state_next = rd_en ? ST_READ : ST_OUT;
        end
      end
      ST_READ: begin
        if (rd_to_front) begin
          front_word_next = rd_data;
        end else begin
          back_word_next = rd_data;
        end
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      default: begin
        state_next = ST_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EXEC;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    front_word   <= front_word_next;
    back_word    <= back_word_next;
    rd_to_front  <= rd_to_front_next;
    popped_value <= popped_value_next;
    popped_valid <= popped_valid_next;
    push_dropped <= push_dropped_next;
  end

  // Result fields from the highest bit down; ends read as zero when empty.
  assign result = {push_dropped,
                   (count != '0) ? back_word : '0,
                   (count != '0) ? front_word : '0,
                   (count == '0),
                   count,
                   popped_value};

  // Output register for the result transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= TDW'(result);
      m_tuser <= {count != '0, popped_valid};
    end
  end

endmodule
